[hdl/ibt_pkg.sv]
// ============================================================================
// ibt_pkg
// Shared constants, status codes and control types for the interval
// booking table.
// ============================================================================
package ibt_pkg;

    localparam int CAPACITY  = 64;
    localparam int TIME_BITS = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_BOOKED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic ready;
        logic load;
        logic rd;
        logic post;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } t_ctl_sts;

endpackage

[hdl/ibt_ram.sv]
// ============================================================================
// ibt_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module ibt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ibt_ctrl.sv]
// ============================================================================
// ibt_ctrl
// Request sequencer: accept, scan stored slots, then decide and post.
// ============================================================================
module ibt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  ibt_pkg::t_ctl_sts i_sts,
    output ibt_pkg::t_ctl_cmd o_cmd
);
    import ibt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                o_cmd.load  = i_s_tvalid;
            end
            S_SCAN: begin
                o_cmd.rd = !i_sts.scan_end;
            end
            S_DONE: begin
                o_cmd.post = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTH
    a_load_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_SCAN)
        else $error("accepted request did not start a scan");
    a_post_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.post |=> r_state == S_IDLE)
        else $error("posted result did not return to idle");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.rd, o_cmd.post}))
        else $error("more than one datapath command at once");
`endif

endmodule

[hdl/ibt_dp.sv]
// ============================================================================
// ibt_dp
// Datapath: request registers, slot memories, scan counter, overlap
// accumulator, fill count and result register.
// ============================================================================
module ibt_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ibt_pkg::t_ctl_cmd               i_cmd,
    input  logic [ibt_pkg::TIME_BITS-1:0]   i_start_time,
    input  logic [ibt_pkg::TIME_BITS-1:0]   i_end_time,
    input  logic                            i_m_tready,
    output ibt_pkg::t_ctl_sts               o_sts,
    output logic                            o_m_tvalid,
    output logic [1:0]                      o_status
);
    import ibt_pkg::*;

    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_end;
    logic [CNT_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_count;
    logic                 r_rd_pend;
    logic                 r_hit;
    logic                 r_out_valid;
    t_status              r_status;

    logic [TIME_BITS-1:0] rd_start;
    logic [TIME_BITS-1:0] rd_end;
    logic                 hit_now;
    logic                 we;
    t_status              n_status;

    ibt_ram #(.WIDTH(TIME_BITS), .DEPTH(CAPACITY)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_start),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_start)
    );

    ibt_ram #(.WIDTH(TIME_BITS), .DEPTH(CAPACITY)) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_end),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_end)
    );

    assign hit_now = (rd_start < r_end) && (rd_end > r_start);

    always_comb begin
        priority if (!(r_start < r_end)) begin
            n_status = ST_INVALID;
        end else if (r_hit) begin
            n_status = ST_OVERLAP;
        end else if (r_count == CAP_CNT) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_BOOKED;
        end
    end

    assign we = i_cmd.post && (n_status == ST_BOOKED);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_start_time;
            r_end   <= i_end_time;
        end
        if (i_cmd.post) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd;
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.rd) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_rd_pend && hit_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (we) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.scan_end = (r_idx == r_count);
    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_status       = r_status;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("fill count beyond capacity");
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_count < CAP_CNT) && !r_hit && (r_start < r_end))
        else $error("slot written for a refused request");
    a_read_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> r_idx < r_count)
        else $error("scan read of an unused slot");
`endif

endmodule

[hdl/interval_booking_table_core.sv]
// ============================================================================
// interval_booking_table_core
// Reservation table of half-open intervals [start,end): books a request
// that overlaps no stored interval into the next free slot, else refuses it
// with a reason code.
// ============================================================================
//  channel | dir | tdata fields (low bit up)            | tuser
//  s       | in  | start_time[31:0], end_time[63:32]    | -
//  m       | out | status[1:0], zero pad [7:2]          | -
//
//  A request passes an accept state, a scan with one slot memory read per
//  stored interval plus the last compare, and a decide/write state.
//  Reset empties the table at once through the fill count; no sweep.
//  A finished result waits in the output register; the next request is
//  accepted meanwhile and only its decide cycle waits on i_m_tready.
// ============================================================================
module interval_booking_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // start_time[31:0], end_time[63:32]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // status[1:0], zero[7:2]
);
    import ibt_pkg::*;

    t_ctl_cmd   cmd;
    t_ctl_sts   sts;
    logic [1:0] status;

    ibt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ibt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_start_time (i_s_tdata[31:0]),
        .i_end_time   (i_s_tdata[63:32]),
        .i_m_tready   (i_m_tready),
        .o_sts        (sts),
        .o_m_tvalid   (o_m_tvalid),
        .o_status     (status)
    );

    assign o_s_tready = cmd.ready;
    assign o_m_tdata  = {6'd0, status};

endmodule

[tb/sv/interval_booking_table_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// interval_booking_table_core_tb
// Self-checking bench for the interval booking table. A queue of requests
// (directed edge cases, then random probes around earlier intervals, fresh
// intervals, reversed/empty intervals and extreme values) feeds a stream
// driver. An in-bench shadow table predicts the status of every accepted
// beat. A monitor checks each result beat in order against the prediction.
// Sender and receiver idle at random in the first two of three phases.
// ============================================================================
module interval_booking_table_core_tb;
    import ibt_pkg::*;

    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } t_booking_req;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;

    t_booking_req request_q[$];
    t_booking_req anchor_q[$];
    t_status      pending_status_q[$];

    // shadow of the booking table
    logic [31:0] shadow_lo [CAPACITY];
    logic [31:0] shadow_hi [CAPACITY];
    logic        shadow_used [CAPACITY];

    int total_items = 0;
    int sent_cnt = 0;
    int result_cnt = 0;
    int err_cnt = 0;
    int status_seen [4];

    interval_booking_table_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),      // start_time[31:0], end_time[63:32]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)     // status[1:0], zero[7:2]
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic t_status reserve_interval(logic [31:0] lo, logic [31:0] hi);
        if (lo >= hi) return ST_INVALID;
        for (int i = 0; i < CAPACITY; i++) begin
            if (shadow_used[i] && shadow_lo[i] < hi && shadow_hi[i] > lo) return ST_OVERLAP;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (!shadow_used[i]) begin
                shadow_lo[i]   = lo;
                shadow_hi[i]   = hi;
                shadow_used[i] = 1'b1;
                return ST_BOOKED;
            end
        end
        return ST_FULL;
    endfunction

    // idle percentages per phase: sender/receiver 31/68, then 68/31, then none
    function automatic int tx_idle_pct();
        if (sent_cnt < total_items / 3) return 31;
        if (sent_cnt < 2 * total_items / 3) return 68;
        return 0;
    endfunction

    function automatic int rx_idle_pct();
        if (sent_cnt < total_items / 3) return 68;
        if (sent_cnt < 2 * total_items / 3) return 31;
        return 0;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_sub(logic [31:0] a, logic [31:0] b);
        return (a < b) ? 32'd0 : a - b;
    endfunction

    function automatic logic [31:0] rand_width();
        int k;
        k = $urandom_range(20);
        return 32'($urandom_range((1 << k) - 1)) + 32'd1;
    endfunction

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'hFFFF_FFFE;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic add_req(logic [31:0] lo, logic [31:0] hi);
        t_booking_req r;
        r.lo = lo;
        r.hi = hi;
        request_q.insert(request_q.size(), r);
        if (lo < hi) begin
            if (anchor_q.size() >= 200) anchor_q[$urandom_range(199)] = r;
            else anchor_q.insert(anchor_q.size(), r);
        end
    endtask

    task automatic add_random_req();
        t_booking_req a;
        logic [31:0]  w;
        int           sel;
        sel = $urandom_range(99);
        w   = rand_width();
        if (sel < 55 && anchor_q.size() > 0) begin
            // probe around an earlier interval: edges, touching, inside
            a = anchor_q[$urandom_range(anchor_q.size() - 1)];
            case ($urandom_range(5))
                0: add_req(a.lo, a.hi);
                1: add_req(a.hi, sat_add(a.hi, w));
                2: add_req(sat_sub(a.lo, w), a.lo);
                3: add_req(a.hi - 32'd1, sat_add(a.hi, w));
                4: add_req(sat_sub(a.lo, w), a.lo + 32'd1);
                default: add_req(sat_add(a.lo, w % (a.hi - a.lo)), sat_add(a.lo, w));
            endcase
        end else if (sel < 85) begin
            a.lo = $urandom();
            add_req(a.lo, sat_add(a.lo, w));
        end else if (sel < 95) begin
            a.lo = $urandom();
            add_req(a.lo, a.lo - 32'($urandom_range(3)));
        end else begin
            add_req(extreme_value(), extreme_value());
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        t_booking_req r;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                pending_status_q.insert(pending_status_q.size(),
                                        reserve_interval(s_tdata[31:0], s_tdata[63:32]));
                sent_cnt++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (request_q.size() > 0 && $urandom_range(99) >= tx_idle_pct()) begin
                    r = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {r.hi, r.lo};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_status exp_st;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (pending_status_q.size() == 0) begin
                    report_mismatch($sformatf("result beat 0x%02h with nothing expected",
                                              o_m_tdata));
                end else begin
                    exp_st = pending_status_q.pop_front();
                    status_seen[exp_st]++;
                    if (o_m_tdata[1:0] !== exp_st)
                        report_mismatch($sformatf("result %0d: status %0d, expected %s",
                                                  result_cnt, o_m_tdata[1:0], exp_st.name()));
                    if (o_m_tdata[7:2] !== '0)
                        report_mismatch($sformatf("result %0d: pad bits 0x%02h not zero",
                                                  result_cnt, o_m_tdata[7:2]));
                    result_cnt++;
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct());
        end
    end

    initial begin : main
        for (int i = 0; i < CAPACITY; i++) shadow_used[i] = 1'b0;
        for (int i = 0; i < 4; i++) status_seen[i] = 0;

        // directed: empty and reversed intervals, extremes, touching and overlapping edges
        add_req(32'h0000_0000, 32'h0000_0000);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(32'hFFFF_FFFF, 32'h0000_0000);
        add_req(32'h0000_0005, 32'h0000_0004);
        add_req(32'h0000_0000, 32'h0000_0001);
        add_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        add_req(32'h0000_0000, 32'hFFFF_FFFF);
        add_req(32'h0000_0001, 32'h0000_000A);
        add_req(32'h0000_0009, 32'h0000_000A);
        add_req(32'h0000_000A, 32'h0000_0014);
        add_req(32'h0000_0000, 32'h0000_0001);
        add_req(32'h0000_000F, 32'h0000_0010);
        add_req(32'h0000_0005, 32'h0000_0019);
        add_req(32'h0000_0014, 32'h0000_0015);
        add_req(32'hAAAA_AAAA, 32'h5555_5555);
        add_req(32'h5555_5555, 32'hAAAA_AAAA);
        add_req(32'h8000_0000, 32'h8000_0001);
        add_req(32'hAAAA_AAAA, 32'hAAAA_AAAB);
        add_req(32'h7FFF_FFFF, 32'h8000_0000);
        add_req(32'hFFFF_FFFD, 32'hFFFF_FFFF);
        add_req(32'hFFFF_FFFD, 32'hFFFF_FFFE);

        // random: the table fills along the way, later requests see a full table
        for (int n = 0; n < 1530; n++) add_random_req();
        total_items = request_q.size();

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        while (sent_cnt < total_items) @(posedge i_clk);
        while (pending_status_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Requests: %0d accepted, %0d results checked across three idling phases.",
                 sent_cnt, result_cnt);
        $display("Statuses: booked %0d, overlap %0d, full %0d, invalid %0d.",
                 status_seen[ST_BOOKED], status_seen[ST_OVERLAP],
                 status_seen[ST_FULL], status_seen[ST_INVALID]);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Timeout after %0d of %0d requests, %0d results.",
                 sent_cnt, total_items, result_cnt);
        $display("TEST FAILED");
        $finish;
    end

endmodule
